// ===== rtl/psct_pkg.sv =====
// Package for the plane set containment test.
// Holds item types, register indexes, sphere classes and default sizes.
// No dependencies.
package psct_pkg;

  localparam int MAX_PLANES_DEFAULT = 6;
  localparam int MID_DEPTH_DEFAULT  = 8;
  localparam int CFG_IDX_W          = 8;
  localparam int CFG_DATA_W         = 64;
  localparam int DIST_W             = 34;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_PLANES = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_FIRST   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_AT_FIRST = 8'd7;

  typedef enum logic [1:0] {
    CLS_INSIDE   = 2'd0,
    CLS_CROSSING = 2'd1,
    CLS_OUTSIDE  = 2'd2
  } sphere_cls_t;

  typedef struct packed {
    logic signed [15:0] d;
    logic signed [15:0] c;
    logic signed [15:0] b;
    logic signed [15:0] a;
  } plane_t;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic        [15:0] radius;
    logic               list_end;
  } in_item_t;

  typedef struct packed {
    logic        contained;
    sphere_cls_t sphere_class;
    logic [15:0] vertex_index;
    logic        any_in_list;
    logic        last_of_list;
  } out_item_t;

  typedef struct packed {
    logic        contained;
    sphere_cls_t sphere_class;
    logic        list_end;
  } mid_item_t;

endpackage

// ===== rtl/psct_front.sv =====
// Front part: configuration registers and the plane distance pipeline.
// Multiplies, sums and classifies each item against all planes in parallel.
// Depends on psct_pkg.
module psct_front #(
  parameter int MAX_PLANES = psct_pkg::MAX_PLANES_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [psct_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psct_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               accept,
  input  psct_pkg::in_item_t                 in_item,
  output logic                               mid_push,
  output psct_pkg::mid_item_t                mid_item,
  output logic                               stop_at_first
);
  import psct_pkg::*;

  logic [2:0]  active_r;
  logic        stop_r;
  plane_t      plane_r [MAX_PLANES];

  logic        s1_vld_r, s2_vld_r, s3_vld_r;
  in_item_t    s1_item_r, s2_item_r;
  logic signed [31:0]       prod_r [MAX_PLANES][3];
  logic signed [DIST_W-1:0] dist_r [MAX_PLANES];
  mid_item_t   mid_r, mid_nxt;

  logic [2:0]  n_eff;
  logic [MAX_PLANES-1:0] act_v, neg_v, out_v, in_v;
  logic signed [DIST_W-1:0] rad_pos, rad_neg;
  logic        any_neg, any_out, all_in;

  assign n_eff = (active_r > 3'(MAX_PLANES)) ? 3'(MAX_PLANES) : active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 3'd0;
      stop_r   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ACTIVE_PLANES: active_r <= cfg_data[2:0];
        REG_STOP_AT_FIRST: stop_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  genvar p;
  generate
    for (p = 0; p < MAX_PLANES; p++) begin : g_plane
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          plane_r[p] <= '0;
        end else if (cfg_valid && cfg_index == CFG_IDX_W'(int'(REG_PLANE_FIRST) + p)) begin
          plane_r[p] <= plane_t'(cfg_data);
        end
      end

      always_ff @(posedge clk) begin
        prod_r[p][0] <= plane_r[p].a * in_item.pos_x;
        prod_r[p][1] <= plane_r[p].b * in_item.pos_y;
        prod_r[p][2] <= plane_r[p].c * in_item.pos_z;
        dist_r[p]    <= DIST_W'(prod_r[p][0]) + DIST_W'(prod_r[p][1])
                      + DIST_W'(prod_r[p][2])
                      + $signed({{4{plane_r[p].d[15]}}, plane_r[p].d, 14'd0});
      end

      assign act_v[p] = (3'(p) < n_eff);
      assign neg_v[p] = act_v[p] && (dist_r[p] < 0);
      assign out_v[p] = act_v[p] && (dist_r[p] < rad_neg);
      assign in_v[p]  = !act_v[p] || (dist_r[p] > rad_pos);
    end
  endgenerate

  assign rad_pos = $signed({4'd0, s2_item_r.radius, 14'd0});
  assign rad_neg = -rad_pos;
  assign any_neg = |neg_v;
  assign any_out = |out_v;
  assign all_in  = &in_v;

  always_comb begin
    mid_nxt.list_end = s2_item_r.list_end;
    if (n_eff == 3'd0) begin
      mid_nxt.contained    = 1'b0;
      mid_nxt.sphere_class = s2_item_r.mode ? CLS_OUTSIDE : CLS_INSIDE;
    end else if (!s2_item_r.mode) begin
      mid_nxt.contained    = !any_neg;
      mid_nxt.sphere_class = CLS_INSIDE;
    end else begin
      mid_nxt.contained    = !any_out;
      mid_nxt.sphere_class = any_out ? CLS_OUTSIDE : (all_in ? CLS_INSIDE : CLS_CROSSING);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= in_item;
    s2_item_r <= s1_item_r;
    mid_r     <= mid_nxt;
  end

  assign mid_push      = s3_vld_r;
  assign mid_item      = mid_r;
  assign stop_at_first = stop_r;

endmodule

// ===== rtl/psct_queue.sv =====
// Queue between front and back parts, with slot reservation at input accept.
// Counts items in flight in the front pipeline so none can overflow the queue.
// Depends on psct_pkg.
module psct_queue #(
  parameter int DEPTH = psct_pkg::MID_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 reserve,
  output logic                 full,
  input  logic                 wr_en,
  input  psct_pkg::mid_item_t  wr_item,
  input  logic                 rd_en,
  output logic                 empty,
  output psct_pkg::mid_item_t  rd_item
);
  import psct_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mid_item_t        mem [DEPTH];
  mid_item_t        rd_item_r;
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, used_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
  end

  // Hold the head entry in a register; bypass a write into the slot read next
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_item;
    end
    if (wr_en && (wr_ptr_r == rd_ptr_nxt)) begin
      rd_item_r <= wr_item;
    end else begin
      rd_item_r <= mem[rd_ptr_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      used_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_r + CW'(wr_en) - CW'(rd_en);
      used_r   <= used_r + CW'(reserve) - CW'(rd_en);
    end
  end

  assign full    = (used_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_item = rd_item_r;

endmodule

// ===== rtl/psct_back.sv =====
// Back part: list position, first-hit tracking and the result register.
// Takes classified items from the queue and presents results queue-style.
// Depends on psct_pkg.
module psct_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 stop_at_first,
  input  logic                 mid_empty,
  input  psct_pkg::mid_item_t  mid_item,
  output logic                 mid_pop,
  input  logic                 pop,
  output logic                 empty,
  output psct_pkg::out_item_t  out_item
);
  import psct_pkg::*;

  logic        out_vld_r;
  out_item_t   out_r, out_nxt;
  logic [15:0] pos_r;
  logic        hit_r;
  logic        take, hit_now;

  assign take    = !mid_empty && (!out_vld_r || pop);
  assign hit_now = hit_r || out_nxt.contained;

  always_comb begin
    out_nxt.contained    = mid_item.contained && !(stop_at_first && hit_r);
    out_nxt.sphere_class = mid_item.sphere_class;
    out_nxt.vertex_index = pos_r;
    out_nxt.any_in_list  = hit_r || (mid_item.contained && !(stop_at_first && hit_r));
    out_nxt.last_of_list = mid_item.list_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      pos_r     <= '0;
      hit_r     <= 1'b0;
    end else begin
      if (take) begin
        out_vld_r <= 1'b1;
        if (mid_item.list_end) begin
          pos_r <= '0;
          hit_r <= 1'b0;
        end else begin
          hit_r <= hit_now;
          if (pos_r != 16'hFFFF) begin
            pos_r <= pos_r + 16'd1;
          end
        end
      end else if (pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= out_nxt;
    end
  end

  assign mid_pop  = take;
  assign empty    = !out_vld_r;
  assign out_item = out_r;

endmodule

// ===== rtl/plane_set_containment_test.sv =====
// Top level of the plane set containment test.
// Joins psct_front, psct_queue and psct_back; depends on psct_pkg.
//
// Input channel: an item is taken on a clock edge with push high and full low.
// Each item is tested against up to six planes, all in parallel.
// Result channel: while empty is low the oldest result sits on out_item; it
// is taken on an edge with pop high.
// Configuration: cfg_ready is always high; a transaction writes register
// cfg_index with cfg_data. Unknown indexes are dropped. Write only when idle.
// Pipeline: an item passes the multiply, sum and classify stages, the queue and
// the result register. Throughput is one item per cycle while full stays low,
// through the three-stage multiply, sum and classify pipeline feeding an 8-entry queue.
// Stall: when pop is held low, the queue absorbs the items in flight; full
// rises once the queue slots are all reserved and falls as results drain.
// Reset (synchronous, rst_n low): queues empty, list position and hit flag
// cleared, configuration and plane registers zero; full is low straight after reset.
module plane_set_containment_test #(
  parameter int MAX_PLANES = psct_pkg::MAX_PLANES_DEFAULT,
  parameter int MID_DEPTH  = psct_pkg::MID_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  psct_pkg::in_item_t              in_item,
  output logic                            empty,
  input  logic                            pop,
  output psct_pkg::out_item_t             out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [psct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psct_pkg::CFG_DATA_W-1:0] cfg_data
);
  import psct_pkg::*;

  logic      accept;
  logic      mid_push, mid_pop, mid_empty;
  mid_item_t mid_wr_item, mid_rd_item;
  logic      stop_at_first;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  psct_front #(
    .MAX_PLANES (MAX_PLANES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .in_item       (in_item),
    .mid_push      (mid_push),
    .mid_item      (mid_wr_item),
    .stop_at_first (stop_at_first)
  );

  psct_queue #(
    .DEPTH (MID_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .reserve (accept),
    .full    (full),
    .wr_en   (mid_push),
    .wr_item (mid_wr_item),
    .rd_en   (mid_pop),
    .empty   (mid_empty),
    .rd_item (mid_rd_item)
  );

  psct_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .stop_at_first (stop_at_first),
    .mid_empty     (mid_empty),
    .mid_item      (mid_rd_item),
    .mid_pop       (mid_pop),
    .pop           (pop),
    .empty         (empty),
    .out_item      (out_item)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for plane_set_containment_test: point and sphere tests
// against up to six planes, list indexing and stop-after-first-hit behaviour.
// Depends on psct_pkg and the plane_set_containment_test RTL only.
module testbench;
  import psct_pkg::*;

  localparam int MAX_PLANES = MAX_PLANES_DEFAULT;
  localparam int LATENCY = 4;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int LONG_LIST_LEN = 200;
  localparam int RAND_PHASES = 10;
  localparam int RAND_PHASE_ITEMS = 160;
  localparam int MAX_REPORTS = 40;

  localparam logic MODE_POINT = 1'b0;
  localparam logic MODE_SPHERE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = REG_STOP_AT_FIRST + CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HIGH = '1;

  localparam logic [15:0] ONE_Q14 = 16'sd16384;
  localparam logic [15:0] NEG_ONE_Q14 = -16'sd16384;
  localparam logic [15:0] COORD_MAX = 16'h7FFF;
  localparam logic [15:0] COORD_MIN = 16'h8000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  in_item_t in_item = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the registers and list state
  logic [2:0] act_planes = '0;
  plane_t planes [MAX_PLANES];
  logic stop_first = 1'b0;
  logic [15:0] list_pos = '0;
  logic hit_flag = 1'b0;

  out_item_t verdict_q [$];
  int mismatch_count = 0;
  int items_sent = 0;
  int lists_done = 0;
  int reg_writes = 0;
  int cycle_count = 0;
  int pop_wait = 0;
  bit push_stalls = 1'b1;
  bit pop_stalls = 1'b1;

  plane_set_containment_test u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_item(in_item),
    .empty(empty),
    .pop(pop),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    for (int k = 0; k < MAX_PLANES; k++) planes[k] = '0;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [CFG_IDX_W-1:0] plane_reg(int k);
    return CFG_IDX_W'(int'(REG_PLANE_FIRST) + k);
  endfunction

  function automatic longint plane_dist(plane_t p, in_item_t it);
    return longint'(p.a) * longint'(it.pos_x) + longint'(p.b) * longint'(it.pos_y) +
           longint'(p.c) * longint'(it.pos_z) + longint'(p.d) * 16384;
  endfunction

  function automatic out_item_t containment_verdict(in_item_t it);
    int n;
    longint plane_d;
    longint rad;
    logic hit;
    logic any_out;
    logic all_in;
    sphere_cls_t cls;
    out_item_t res;
    n = (int'(act_planes) > MAX_PLANES) ? MAX_PLANES : int'(act_planes);
    rad = longint'(it.radius) * 16384;
    cls = CLS_INSIDE;
    if (n == 0) begin
      hit = 1'b0;
      cls = (it.mode == MODE_SPHERE) ? CLS_OUTSIDE : CLS_INSIDE;
    end else if (it.mode == MODE_POINT) begin
      hit = 1'b1;
      for (int k = 0; k < n; k++)
        if (plane_dist(planes[k], it) < 0) hit = 1'b0;
    end else begin
      any_out = 1'b0;
      all_in = 1'b1;
      for (int k = 0; k < n; k++) begin
        plane_d = plane_dist(planes[k], it);
        if (plane_d < -rad) begin
          any_out = 1'b1;
          all_in = 1'b0;
        end else if (plane_d <= rad) begin
          all_in = 1'b0;
        end
      end
      cls = any_out ? CLS_OUTSIDE : (all_in ? CLS_INSIDE : CLS_CROSSING);
      hit = !any_out;
    end
    if (stop_first && hit_flag) hit = 1'b0;
    if (hit) hit_flag = 1'b1;
    res.contained = hit;
    res.sphere_class = cls;
    res.vertex_index = list_pos;
    res.any_in_list = hit_flag;
    res.last_of_list = it.list_end;
    if (it.list_end) begin
      list_pos = '0;
      hit_flag = 1'b0;
    end else if (list_pos != 16'hFFFF) begin
      list_pos = list_pos + 16'd1;
    end
    return res;
  endfunction

  function automatic in_item_t make_item(logic mode, logic [15:0] x, logic [15:0] y,
                                         logic [15:0] z, logic [15:0] r, logic last);
    in_item_t it;
    it.mode = mode;
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.radius = r;
    it.list_end = last;
    return it;
  endfunction

  function automatic logic [63:0] pack_plane(logic [15:0] a, logic [15:0] b,
                                             logic [15:0] c, logic [15:0] d);
    plane_t p;
    p.a = a;
    p.b = b;
    p.c = c;
    p.d = d;
    return p;
  endfunction

  function automatic logic [63:0] box_plane(int k, logic [15:0] h);
    case (k)
      0: return pack_plane(ONE_Q14, '0, '0, h);
      1: return pack_plane(NEG_ONE_Q14, '0, '0, h);
      2: return pack_plane('0, ONE_Q14, '0, h);
      3: return pack_plane('0, NEG_ONE_Q14, '0, h);
      4: return pack_plane('0, '0, ONE_Q14, h);
      default: return pack_plane('0, '0, NEG_ONE_Q14, h);
    endcase
  endfunction

  function automatic logic [15:0] rand_coord(int span);
    int v;
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    v = int'($urandom_range(0, 2 * span)) - span;
    return v[15:0];
  endfunction

  function automatic in_item_t rand_item(int span, logic last);
    logic [15:0] r;
    if ($urandom_range(0, 3) == 0) r = 16'($urandom);
    else r = 16'($urandom_range(0, span));
    return make_item(1'($urandom_range(0, 1)), rand_coord(span), rand_coord(span),
                     rand_coord(span), r, last);
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Check each popped transaction and drive pop with random stalls
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (pop && !empty) begin
      if (verdict_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t unexpected result: expected none, actual %0h", $time, out_item);
      end else begin
        want = verdict_q.pop_front();
        check_field("contained", 16'(want.contained), 16'(out_item.contained));
        check_field("sphere_class", 16'(want.sphere_class), 16'(out_item.sphere_class));
        check_field("vertex_index", want.vertex_index, out_item.vertex_index);
        check_field("any_in_list", 16'(want.any_in_list), 16'(out_item.any_in_list));
        check_field("last_of_list", 16'(want.last_of_list), 16'(out_item.last_of_list));
      end
    end
    if (!rst_n || pop_wait > 0) begin
      pop <= 1'b0;
      if (pop_wait > 0) pop_wait = pop_wait - 1;
    end else begin
      pop <= 1'b1;
      pop_wait = pop_stalls ? pick_gap() : 0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles, %0d results outstanding", cycle_count,
               verdict_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_item(input in_item_t it);
    int gap;
    gap = push_stalls ? pick_gap() : 0;
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    verdict_q = {verdict_q, containment_verdict(it)};
    items_sent++;
    if (it.list_end) lists_done++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    if (idx == REG_ACTIVE_PLANES) act_planes = data[2:0];
    else if (idx >= REG_PLANE_FIRST && idx < REG_PLANE_FIRST + MAX_PLANES)
      planes[3'(idx - REG_PLANE_FIRST)] = data;
    else if (idx == REG_STOP_AT_FIRST) stop_first = data[0];
  endtask

  task automatic drain();
    push <= 1'b0;
    cfg_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  task automatic load_box(input logic [15:0] h);
    for (int k = 0; k < MAX_PLANES; k++) write_reg(plane_reg(k), box_plane(k, h));
  endtask

  task automatic test_empty_set();
    send_item(make_item(MODE_POINT, COORD_MAX, COORD_MIN, '0, '0, 1'b0));
    send_item(make_item(MODE_SPHERE, COORD_MIN, COORD_MAX, COORD_MAX, 16'hFFFF, 1'b1));
  endtask

  task automatic test_boundary();
    drain();
    write_reg(REG_ACTIVE_PLANES, 64'd1);
    write_reg(REG_PLANE_FIRST, pack_plane(ONE_Q14, '0, '0, '0));
    write_reg(REG_STOP_AT_FIRST, 64'd0);
    send_item(make_item(MODE_POINT, '0, '0, '0, '0, 1'b0));
    send_item(make_item(MODE_POINT, -16'sd1, '0, '0, '0, 1'b0));
    send_item(make_item(MODE_SPHERE, 16'sd256, '0, '0, 16'd256, 1'b0));
    send_item(make_item(MODE_SPHERE, -16'sd256, '0, '0, 16'd256, 1'b0));
    send_item(make_item(MODE_SPHERE, 16'sd512, '0, '0, 16'd256, 1'b0));
    send_item(make_item(MODE_SPHERE, -16'sd512, '0, '0, 16'd256, 1'b0));
    send_item(make_item(MODE_SPHERE, '0, '0, '0, '0, 1'b1));
  endtask

  task automatic test_extremes();
    drain();
    write_reg(REG_ACTIVE_PLANES, 64'd6);
    write_reg(plane_reg(0), pack_plane(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
    write_reg(plane_reg(1), pack_plane(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
    write_reg(plane_reg(2), '1);
    write_reg(plane_reg(3), '0);
    write_reg(plane_reg(4), pack_plane(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    write_reg(plane_reg(5), pack_plane(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_item(make_item(MODE_POINT, COORD_MAX, COORD_MAX, COORD_MAX, 16'hFFFF, 1'b0));
    send_item(make_item(MODE_POINT, COORD_MIN, COORD_MIN, COORD_MIN, '0, 1'b0));
    send_item(make_item(MODE_SPHERE, COORD_MAX, COORD_MAX, COORD_MAX, 16'hFFFF, 1'b0));
    send_item(make_item(MODE_SPHERE, COORD_MIN, COORD_MIN, COORD_MIN, '0, 1'b1));
  endtask

  task automatic test_plane_count_overflow();
    drain();
    write_reg(REG_ACTIVE_PLANES, '1);
    load_box(16'h0400);
    send_item(make_item(MODE_POINT, '0, '0, '0, '0, 1'b0));
    send_item(make_item(MODE_SPHERE, 16'h0300, '0, '0, 16'h0200, 1'b1));
  endtask

  task automatic test_stop_at_first();
    drain();
    write_reg(REG_ACTIVE_PLANES, 64'd6);
    write_reg(REG_STOP_AT_FIRST, '1);
    send_item(make_item(MODE_POINT, '0, '0, '0, '0, 1'b0));
    send_item(make_item(MODE_POINT, '0, '0, '0, '0, 1'b0));
    send_item(make_item(MODE_POINT, 16'h0800, '0, '0, '0, 1'b0));
    send_item(make_item(MODE_SPHERE, '0, '0, '0, 16'h0100, 1'b0));
    send_item(make_item(MODE_POINT, '0, '0, '0, '0, 1'b1));
    send_item(make_item(MODE_POINT, '0, '0, '0, '0, 1'b1));
  endtask

  task automatic test_unknown_register();
    drain();
    write_reg(REG_UNUSED_LOW, '1);
    write_reg(REG_UNUSED_HIGH, '1);
    send_item(make_item(MODE_POINT, '0, '0, '0, '0, 1'b0));
    send_item(make_item(MODE_SPHERE, 16'h0500, '0, '0, 16'h0080, 1'b1));
  endtask

  task automatic test_long_list();
    drain();
    push_stalls = 1'b0;
    pop_stalls = 1'b0;
    write_reg(REG_ACTIVE_PLANES, 64'd1);
    write_reg(REG_STOP_AT_FIRST, 64'($urandom_range(0, 1)));
    for (int k = 0; k < LONG_LIST_LEN; k++)
      send_item(rand_item(16'h0800, k == LONG_LIST_LEN - 1));
    push_stalls = 1'b1;
    pop_stalls = 1'b1;
  endtask

  task automatic test_random_phases();
    int sent;
    int len;
    int span;
    int style;
    int h;
    logic [63:0] data;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain();
      push_stalls = ($urandom_range(0, 3) != 0);
      pop_stalls = ($urandom_range(0, 3) != 0);
      if (phase % 5 == 4) begin
        push_stalls = 1'b0;
        pop_stalls = 1'b0;
      end
      style = $urandom_range(0, 2);
      h = $urandom_range(0, 16'h3FFF);
      span = (style == 2) ? 32767 : h + h / 2 + 16;
      data = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0: data[2:0] = 3'd0;
        1: data[2:0] = 3'd7;
        default: data[2:0] = 3'($urandom_range(1, 6));
      endcase
      write_reg(REG_ACTIVE_PLANES, data);
      for (int k = 0; k < MAX_PLANES; k++) begin
        if (style == 0) begin
          data = box_plane(k, 16'(h));
        end else if (style == 1) begin
          a = 16'(int'($urandom_range(0, 32768)) - 16384);
          b = 16'(int'($urandom_range(0, 32768)) - 16384);
          c = 16'(int'($urandom_range(0, 32768)) - 16384);
          data = pack_plane(a, b, c, rand_coord(span));
        end else begin
          data = {$urandom, $urandom};
        end
        write_reg(plane_reg(k), data);
      end
      write_reg(REG_STOP_AT_FIRST, {$urandom, $urandom});
      sent = 0;
      while (sent < RAND_PHASE_ITEMS) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
        for (int k = 0; k < len; k++) send_item(rand_item(span, k == len - 1));
        sent += len;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_set();
    test_boundary();
    test_extremes();
    test_plane_count_overflow();
    test_stop_at_first();
    test_unknown_register();
    test_long_list();
    test_random_phases();
    drain();
    $display("Covered %0d items in %0d lists, point and sphere modes, %0d register writes,",
             items_sent, lists_done, reg_writes);
    $display("including empty and oversized plane sets, boundaries and a long list.");
    if (mismatch_count == 0 && verdict_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
